/* hw/rtl/acsc_pkg.sv */
// Shared types and constants for the accumulator/stack CPU core.
// No dependencies; imported by every module of the core.
`default_nettype none

package acsc_pkg;

  // Default memory size in 32-bit words
  localparam int unsigned MEM_WORDS_DEF = 4096;

  // Instruction word layout
  localparam int unsigned OPC_BITS      = 8;
  localparam int unsigned IMM_BITS      = 24;
  localparam logic [7:0]  OPC_MASK      = 8'((1 << OPC_BITS) - 1);

  // Configuration
  localparam int unsigned STACK_TOP_W     = 24;
  localparam logic [23:0] STACK_TOP_RESET = 24'((1 << 23) - 1);
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam logic        CFG_REG_STACK_TOP = 1'b0;

  // Transaction modes
  localparam logic [1:0] MODE_WR    = 2'd0;
  localparam logic [1:0] MODE_RD    = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_STEP  = 2'd3;

  // Run status codes
  localparam logic [1:0] RUN_ACTIVE = 2'd0;
  localparam logic [1:0] RUN_HALTED = 2'd1;
  localparam logic [1:0] RUN_BADOP  = 2'd2;

  // Opcodes
  localparam logic [7:0] OPC_LDC  = 8'd0;
  localparam logic [7:0] OPC_ADC  = 8'd1;
  localparam logic [7:0] OPC_LDL  = 8'd2;
  localparam logic [7:0] OPC_STL  = 8'd3;
  localparam logic [7:0] OPC_LDNL = 8'd4;
  localparam logic [7:0] OPC_STNL = 8'd5;
  localparam logic [7:0] OPC_ADD  = 8'd6;
  localparam logic [7:0] OPC_SUB  = 8'd7;
  localparam logic [7:0] OPC_SHL  = 8'd8;
  localparam logic [7:0] OPC_SHR  = 8'd9;
  localparam logic [7:0] OPC_ADJ  = 8'd10;
  localparam logic [7:0] OPC_A2SP = 8'd11;
  localparam logic [7:0] OPC_SP2A = 8'd12;
  localparam logic [7:0] OPC_CALL = 8'd13;
  localparam logic [7:0] OPC_RET  = 8'd14;
  localparam logic [7:0] OPC_BRZ  = 8'd15;
  localparam logic [7:0] OPC_BRLZ = 8'd16;
  localparam logic [7:0] OPC_BR   = 8'd17;
  localparam logic [7:0] OPC_HALT = 8'd18;

  // Shared ALU operations
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_SHL,
    ALU_SHR
  } alu_op_t;

endpackage

`default_nettype wire

/* hw/rtl/acsc_alu.sv */
// Shared 32-bit add/subtract/shift unit of the CPU core.
// Depends on acsc_pkg (alu_op_t).
`default_nettype none

module acsc_alu
  import acsc_pkg::*;
(
  input  alu_op_t     op,
  input  logic [31:0] x,
  input  logic [31:0] y,
  output logic [31:0] res
);

  logic big_shift;

  // any amount of 32 or more, negative counts as large
  assign big_shift = |y[31:5];

  always_comb begin
    case (op)
      ALU_ADD: res = x + y;
      ALU_SUB: res = x - y;
      ALU_SHL: res = big_shift ? 32'd0 : (x << y[4:0]);
      ALU_SHR: res = big_shift ? {32{x[31]}} : 32'($signed(x) >>> y[4:0]);
      default: res = x + y;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/acsc_wrap.sv */
// Address wrap unit: reduces a 32-bit address modulo MEM_WORDS.
// Power-of-two sizes use a mask; other sizes a reciprocal multiply.
`default_nettype none

module acsc_wrap
  import acsc_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF,
  localparam int unsigned AW = $clog2(MEM_WORDS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req,
  input  logic [31:0]   value,
  output logic          done,
  output logic [AW-1:0] result
);

  localparam bit IS_POW2 = ((1 << AW) == MEM_WORDS);

  if (IS_POW2) begin : g_mask
    assign done   = req;
    assign result = value[AW-1:0];
  end else begin : g_recip
    // q = floor(v / N): t = hi32(v * M), q = (t + ((v - t) >> 1)) >> (AW - 1)
    // with M = floor(2^32 * (2^AW - N) / N) + 1; remainder = v - q * N
    localparam longint unsigned RECIP_FULL =
      (64'd1 << 32) * ((64'd1 << AW) - 64'(MEM_WORDS)) / 64'(MEM_WORDS) + 64'd1;
    localparam logic [31:0] RECIP = 32'(RECIP_FULL);
    localparam logic [31:0] MOD   = 32'(MEM_WORDS);

    typedef enum logic [1:0] {
      W_IDLE,
      W_QUOT,
      W_REM
    } wrap_state_t;

    wrap_state_t   state_r, state_nxt;
    logic          done_r, done_nxt;
    logic [31:0]   val_r, val_nxt;
    logic [31:0]   hi_r, hi_nxt;
    logic [31:0]   quo_r, quo_nxt;
    logic [AW-1:0] rem_r, rem_nxt;
    logic [63:0]   prod;
    logic [31:0]   diff;

    assign prod = {32'd0, value} * {32'd0, RECIP};
    assign diff = val_r - hi_r;

    always_comb begin
      state_nxt = state_r;
      done_nxt  = 1'b0;
      val_nxt   = val_r;
      hi_nxt    = hi_r;
      quo_nxt   = quo_r;
      rem_nxt   = rem_r;
      unique case (state_r)
        W_IDLE: begin
          if (req && !done_r) begin
            val_nxt   = value;
            hi_nxt    = prod[63:32];
            state_nxt = W_QUOT;
          end
        end
        W_QUOT: begin
          quo_nxt   = (hi_r + {1'b0, diff[31:1]}) >> (AW - 1);
          state_nxt = W_REM;
        end
        W_REM: begin
          rem_nxt   = AW'(val_r - 32'(quo_r * MOD));
          done_nxt  = 1'b1;
          state_nxt = W_IDLE;
        end
        default: begin
          state_nxt = W_IDLE;
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        state_r <= W_IDLE;
        done_r  <= 1'b0;
      end else begin
        state_r <= state_nxt;
        done_r  <= done_nxt;
      end
      val_r <= val_nxt;
      hi_r  <= hi_nxt;
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end

    assign done   = done_r;
    assign result = rem_r;
  end

endmodule

`default_nettype wire

/* hw/rtl/accumulator_stack_cpu_core.sv */
// Accumulator/stack CPU core: registers A, B, SP, PC, word memory, sequencer.
// Depends on acsc_pkg, acsc_alu (shared ALU) and acsc_wrap (address wrap).
//
// Input channel (in_valid/in_ready) carries one transaction: mode, address,
// write_word (write word, read word, start, step one instruction). Each returns
// one result on the out_ channel: read data, registers, run status, step count.
// One transaction is in work at a time; in_ready is high only while the
// sequencer is idle. A finished result sits in the output register, so the
// next transaction is accepted while the receiver stalls; a second result
// then waits in the sequencer until the output register drains.
// A power-of-two MEM_WORDS wraps addresses by a mask; other sizes use the
// reciprocal multiply in acsc_wrap, once per read/write and once or twice
// per step (fetch, then load or store). The single memory port and the one
// shared ALU make the sequencer take each transaction state by state.
// Reset clears PC, A, B, status and count, sets SP and stack_top to 8388607;
// memory is undefined until written. stack_top sits at cfg_ byte address 0.
`default_nettype none

module accumulator_stack_cpu_core
  import acsc_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input transactions
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_mode,
  input  logic [11:0]           in_address,
  input  logic [31:0]           in_write_word,
  // result transactions
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_read_word,
  output logic [31:0]           out_pc_value,
  output logic [31:0]           out_sp_value,
  output logic [31:0]           out_reg_a,
  output logic [31:0]           out_reg_b,
  output logic [1:0]            out_run_status,
  output logic [31:0]           out_steps_done,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_IOADDR,   // wrap transaction address
    S_IOMEM,    // memory write or read issue
    S_IORD,     // capture read data
    S_FADDR,    // wrap PC
    S_FETCH,    // instruction read issue
    S_DECODE,   // halt/unknown check, PC+1
    S_EXEC,     // main operation on shared ALU
    S_DADDR,    // wrap data address
    S_DMEM,     // data write or read issue
    S_DLOAD,    // capture load data
    S_COUNT,    // bump step count
    S_DONE      // hand result to output register
  } state_t;

  state_t        state_r, state_nxt;

  // architectural state
  logic [31:0]   pc_r, pc_nxt;
  logic [31:0]   sp_r, sp_nxt;
  logic [31:0]   a_r, a_nxt;
  logic [31:0]   b_r, b_nxt;
  logic [1:0]    stop_r, stop_nxt;
  logic [31:0]   step_r, step_nxt;
  logic [STACK_TOP_W-1:0] stack_top_r, stack_top_nxt;

  // per-transaction working registers
  logic [1:0]    mode_r, mode_nxt;
  logic [31:0]   wdata_r, wdata_nxt;
  logic [31:0]   dval_r, dval_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [31:0]   ir_r, ir_nxt;
  logic [31:0]   rdw_r, rdw_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_rdw_r, out_rdw_nxt;
  logic [31:0]   out_pc_r, out_pc_nxt;
  logic [31:0]   out_sp_r, out_sp_nxt;
  logic [31:0]   out_a_r, out_a_nxt;
  logic [31:0]   out_b_r, out_b_nxt;
  logic [1:0]    out_stat_r, out_stat_nxt;
  logic [31:0]   out_step_r, out_step_nxt;

  // memory
  logic [31:0]   mem_q [MEM_WORDS];
  logic [31:0]   mem_rdata_r;
  logic          mem_we;
  logic [31:0]   mem_wdata;

  // shared units
  alu_op_t       alu_op;
  logic [31:0]   alu_x, alu_y, alu_res;
  logic          wrap_req, wrap_done;
  logic [AW-1:0] wrap_res;

  logic [7:0]    opc;
  logic [31:0]   operand;
  logic          cfg_wr;

  assign opc     = ir_r[OPC_BITS-1:0] & OPC_MASK;
  assign operand = {{(32-IMM_BITS){ir_r[31]}}, ir_r[31:OPC_BITS]};

  acsc_alu u_alu (
    .op  (alu_op),
    .x   (alu_x),
    .y   (alu_y),
    .res (alu_res)
  );

  acsc_wrap #(
    .MEM_WORDS (MEM_WORDS)
  ) u_wrap (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (wrap_req),
    .value  (dval_r),
    .done   (wrap_done),
    .result (wrap_res)
  );

  // Configuration port: zero-wait, register decoded on the word address bit
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == CFG_REG_STACK_TOP) ?
                      {{(32-STACK_TOP_W){1'b0}}, stack_top_r} : 32'd0;

  assign in_ready       = (state_r == S_IDLE);
  assign wrap_req       = (state_r == S_IOADDR) || (state_r == S_FADDR) ||
                          (state_r == S_DADDR);

  assign out_valid      = out_valid_r;
  assign out_read_word  = out_rdw_r;
  assign out_pc_value   = out_pc_r;
  assign out_sp_value   = out_sp_r;
  assign out_reg_a      = out_a_r;
  assign out_reg_b      = out_b_r;
  assign out_run_status = out_stat_r;
  assign out_steps_done = out_step_r;

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    sp_nxt        = sp_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    stop_nxt      = stop_r;
    step_nxt      = step_r;
    stack_top_nxt = stack_top_r;
    mode_nxt      = mode_r;
    wdata_nxt     = wdata_r;
    dval_nxt      = dval_r;
    addr_nxt      = addr_r;
    ir_nxt        = ir_r;
    rdw_nxt       = rdw_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_rdw_nxt   = out_rdw_r;
    out_pc_nxt    = out_pc_r;
    out_sp_nxt    = out_sp_r;
    out_a_nxt     = out_a_r;
    out_b_nxt     = out_b_r;
    out_stat_nxt  = out_stat_r;
    out_step_nxt  = out_step_r;
    mem_we        = 1'b0;
    mem_wdata     = a_r;
    alu_op        = ALU_ADD;
    alu_x         = pc_r;
    alu_y         = 32'd1;

    if (cfg_wr && (cfg_paddr[2] == CFG_REG_STACK_TOP)) begin
      stack_top_nxt = cfg_pwdata[STACK_TOP_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          wdata_nxt = in_write_word;
          rdw_nxt   = 32'd0;
          dval_nxt  = {20'd0, in_address};
          unique case (in_mode)
            MODE_WR, MODE_RD: begin
              state_nxt = S_IOADDR;
            end
            MODE_START: begin
              pc_nxt    = 32'd0;
              sp_nxt    = {{(32-STACK_TOP_W){1'b0}}, stack_top_r};
              a_nxt     = 32'd0;
              b_nxt     = 32'd0;
              step_nxt  = 32'd0;
              stop_nxt  = RUN_ACTIVE;
              state_nxt = S_DONE;
            end
            default: begin
              // step: nothing happens while stopped
              if (stop_r != RUN_ACTIVE) begin
                state_nxt = S_DONE;
              end else begin
                dval_nxt  = pc_r;
                state_nxt = S_FADDR;
              end
            end
          endcase
        end
      end

      S_IOADDR: begin
        if (wrap_done) begin
          addr_nxt  = wrap_res;
          state_nxt = S_IOMEM;
        end
      end

      S_IOMEM: begin
        if (mode_r == MODE_WR) begin
          mem_we    = 1'b1;
          mem_wdata = wdata_r;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_IORD;
        end
      end

      S_IORD: begin
        rdw_nxt   = mem_rdata_r;
        state_nxt = S_DONE;
      end

      S_FADDR: begin
        if (wrap_done) begin
          addr_nxt  = wrap_res;
          state_nxt = S_FETCH;
        end
      end

      S_FETCH: begin
        state_nxt = S_DECODE;
      end

      S_DECODE: begin
        ir_nxt = mem_rdata_r;
        if ((mem_rdata_r[7:0] & OPC_MASK) == OPC_HALT) begin
          stop_nxt  = RUN_HALTED;
          state_nxt = S_DONE;
        end else if ((mem_rdata_r[7:0] & OPC_MASK) > OPC_HALT) begin
          stop_nxt  = RUN_BADOP;
          state_nxt = S_DONE;
        end else begin
          pc_nxt    = alu_res;   // PC + 1 before the instruction acts
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_COUNT;
        alu_x     = pc_r;
        alu_y     = operand;
        case (opc) inside
          OPC_LDC: begin
            b_nxt = a_r;
            a_nxt = operand;
          end
          OPC_ADC: begin
            alu_x = a_r;
            a_nxt = alu_res;
          end
          OPC_LDL, OPC_STL: begin
            alu_x     = sp_r;
            dval_nxt  = alu_res;
            state_nxt = S_DADDR;
          end
          OPC_LDNL, OPC_STNL: begin
            alu_x     = a_r;
            dval_nxt  = alu_res;
            state_nxt = S_DADDR;
          end
          OPC_ADD: begin
            alu_x = b_r;
            alu_y = a_r;
            a_nxt = alu_res;
          end
          OPC_SUB: begin
            alu_op = ALU_SUB;
            alu_x  = b_r;
            alu_y  = a_r;
            a_nxt  = alu_res;
          end
          OPC_SHL: begin
            alu_op = ALU_SHL;
            alu_x  = b_r;
            alu_y  = a_r;
            a_nxt  = alu_res;
          end
          OPC_SHR: begin
            alu_op = ALU_SHR;
            alu_x  = b_r;
            alu_y  = a_r;
            a_nxt  = alu_res;
          end
          OPC_ADJ: begin
            alu_x  = sp_r;
            sp_nxt = alu_res;
          end
          OPC_A2SP: begin
            sp_nxt = a_r;
            a_nxt  = b_r;
          end
          OPC_SP2A: begin
            b_nxt = a_r;
            a_nxt = sp_r;
          end
          OPC_CALL: begin
            b_nxt  = a_r;
            a_nxt  = pc_r;
            pc_nxt = alu_res;
          end
          OPC_RET: begin
            pc_nxt = a_r;
            a_nxt  = b_r;
          end
          OPC_BRZ: begin
            if (a_r == 32'd0) begin
              pc_nxt = alu_res;
            end
          end
          OPC_BRLZ: begin
            if (a_r[31]) begin
              pc_nxt = alu_res;
            end
          end
          default: begin
            // unconditional branch
            pc_nxt = alu_res;
          end
        endcase
      end

      S_DADDR: begin
        if (wrap_done) begin
          addr_nxt  = wrap_res;
          state_nxt = S_DMEM;
        end
      end

      S_DMEM: begin
        state_nxt = S_COUNT;
        case (opc) inside
          OPC_STL: begin
            mem_we    = 1'b1;
            mem_wdata = a_r;
            a_nxt     = b_r;
          end
          OPC_STNL: begin
            mem_we    = 1'b1;
            mem_wdata = b_r;
          end
          default: begin
            state_nxt = S_DLOAD;
          end
        endcase
      end

      S_DLOAD: begin
        if (opc == OPC_LDL) begin
          b_nxt = a_r;
        end
        a_nxt     = mem_rdata_r;
        state_nxt = S_COUNT;
      end

      S_COUNT: begin
        alu_x = step_r;
        if (step_r != 32'hFFFF_FFFF) begin
          step_nxt = alu_res;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rdw_nxt   = rdw_r;
          out_pc_nxt    = pc_r;
          out_sp_nxt    = sp_r;
          out_a_nxt     = a_r;
          out_b_nxt     = b_r;
          out_stat_nxt  = stop_r;
          out_step_nxt  = step_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pc_r        <= 32'd0;
      sp_r        <= {{(32-STACK_TOP_W){1'b0}}, STACK_TOP_RESET};
      a_r         <= 32'd0;
      b_r         <= 32'd0;
      stop_r      <= RUN_ACTIVE;
      step_r      <= 32'd0;
      stack_top_r <= STACK_TOP_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pc_r        <= pc_nxt;
      sp_r        <= sp_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      stop_r      <= stop_nxt;
      step_r      <= step_nxt;
      stack_top_r <= stack_top_nxt;
    end
    mode_r     <= mode_nxt;
    wdata_r    <= wdata_nxt;
    dval_r     <= dval_nxt;
    addr_r     <= addr_nxt;
    ir_r       <= ir_nxt;
    rdw_r      <= rdw_nxt;
    out_rdw_r  <= out_rdw_nxt;
    out_pc_r   <= out_pc_nxt;
    out_sp_r   <= out_sp_nxt;
    out_a_r    <= out_a_nxt;
    out_b_r    <= out_b_nxt;
    out_stat_r <= out_stat_nxt;
    out_step_r <= out_step_nxt;
  end

  // single-port word memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[addr_r] <= mem_wdata;
    end
    mem_rdata_r <= mem_q[addr_r];
  end

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for accumulator_stack_cpu_core: a directed table, then random
// programs, every result checked against an in-bench model of the core. Needs acsc_pkg.

module testbench
  import acsc_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned TAIL_CYCLES  = 12;    // longer than the slowest step latency
  localparam logic [CFG_ADDR_W-1:0] STACK_TOP_ADDR = CFG_ADDR_W'(4 * CFG_REG_STACK_TOP);

  // Everything one result transaction reports
  typedef struct packed {
    logic [31:0] rd;
    logic [31:0] pc;
    logic [31:0] sp;
    logic [31:0] a;
    logic [31:0] b;
    logic [1:0]  st;
    logic [31:0] steps;
  } core_view_t;

  // One row of the directed table; typed rows carry a hand-written expected view
  typedef struct {
    logic [1:0]  mode;
    logic [11:0] addr;
    logic [31:0] word;
    bit          typed;
    core_view_t  view;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [11:0] in_address;
  logic [31:0] in_write_word;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_read_word;
  logic [31:0] out_pc_value;
  logic [31:0] out_sp_value;
  logic [31:0] out_reg_a;
  logic [31:0] out_reg_b;
  logic [1:0]  out_run_status;
  logic [31:0] out_steps_done;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  accumulator_stack_cpu_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_address     (in_address),
    .in_write_word  (in_write_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_word  (out_read_word),
    .out_pc_value   (out_pc_value),
    .out_sp_value   (out_sp_value),
    .out_reg_a      (out_reg_a),
    .out_reg_b      (out_reg_b),
    .out_run_status (out_run_status),
    .out_steps_done (out_steps_done),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  // Model state: the core's registers, its memory and which words hold defined data
  logic [31:0] cpu_pc, cpu_sp, cpu_a, cpu_b, cpu_steps;
  logic [1:0]  cpu_status;
  logic [23:0] cfg_stack_top;
  logic [31:0] mem_model   [0:4095];
  bit          mem_written [0:4095];
  int unsigned written_addrs[$];

  core_view_t  pending_views[$];    // one expected view per accepted input transaction
  stim_row_t   directed_rows[$];
  int unsigned items_sent;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          idle_on;
  string       field_names [0:6] = '{"read_word", "pc_value", "sp_value", "reg_a",
                                     "reg_b", "run_status", "steps_done"};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the core wedges
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic core_view_t make_view(input logic [31:0] rd, pc, sp, a, b,
                                           input logic [1:0] st, input logic [31:0] steps);
    core_view_t v;
    v.rd = rd; v.pc = pc; v.sp = sp; v.a = a; v.b = b; v.st = st; v.steps = steps;
    return v;
  endfunction

  task automatic store_word(input logic [11:0] addr, input logic [31:0] word);
    mem_model[addr] = word;
    if (!mem_written[addr]) begin
      mem_written[addr] = 1'b1;
      written_addrs.push_back(addr);
    end
  endtask

  // Applies one input transaction to the model and returns the view the core must report
  task automatic advance_core(input logic [1:0] mode, input logic [11:0] addr,
                              input logic [31:0] word, output core_view_t v);
    logic [31:0] insn, opnd, daddr;
    logic [7:0]  opc;
    v.rd = '0;
    case (mode)
      MODE_WR: store_word(addr, word);
      MODE_RD: v.rd = mem_model[addr];
      MODE_START: begin
        cpu_pc     = '0;
        cpu_sp     = {8'd0, cfg_stack_top};
        cpu_a      = '0;
        cpu_b      = '0;
        cpu_steps  = '0;
        cpu_status = RUN_ACTIVE;
      end
      default: begin
        if (cpu_status == RUN_ACTIVE) begin
          insn = mem_model[cpu_pc[11:0]];
          opc  = insn[7:0];
          opnd = {{8{insn[31]}}, insn[31:8]};
          if (opc == OPC_HALT) begin
            cpu_status = RUN_HALTED;
          end else if (opc > OPC_HALT) begin
            cpu_status = RUN_BADOP;
          end else begin
            cpu_pc = cpu_pc + 1;    // PC moves before the instruction acts
            case (opc)
              OPC_LDC:  begin cpu_b = cpu_a; cpu_a = opnd; end
              OPC_ADC:  cpu_a = cpu_a + opnd;
              OPC_LDL: begin
                daddr = cpu_sp + opnd;
                cpu_b = cpu_a;
                cpu_a = mem_model[daddr[11:0]];
              end
              OPC_STL: begin
                daddr = cpu_sp + opnd;
                store_word(daddr[11:0], cpu_a);
                cpu_a = cpu_b;
              end
              OPC_LDNL: begin
                daddr = cpu_a + opnd;
                cpu_a = mem_model[daddr[11:0]];
              end
              OPC_STNL: begin
                daddr = cpu_a + opnd;
                store_word(daddr[11:0], cpu_b);
              end
              OPC_ADD:  cpu_a = cpu_b + cpu_a;
              OPC_SUB:  cpu_a = cpu_b - cpu_a;
              // shift amount is A unsigned; 32 and up clears or sign-fills
              OPC_SHL:  cpu_a = (cpu_a >= 32) ? 32'd0 : cpu_b << cpu_a[4:0];
              OPC_SHR:  cpu_a = (cpu_a >= 32) ? {32{cpu_b[31]}}
                                              : 32'($signed(cpu_b) >>> cpu_a[4:0]);
              OPC_ADJ:  cpu_sp = cpu_sp + opnd;
              OPC_A2SP: begin cpu_sp = cpu_a; cpu_a = cpu_b; end
              OPC_SP2A: begin cpu_b = cpu_a; cpu_a = cpu_sp; end
              OPC_CALL: begin cpu_b = cpu_a; cpu_a = cpu_pc; cpu_pc = cpu_pc + opnd; end
              OPC_RET:  begin cpu_pc = cpu_a; cpu_a = cpu_b; end
              OPC_BRZ:  if (cpu_a == 0) cpu_pc = cpu_pc + opnd;
              OPC_BRLZ: if (cpu_a[31]) cpu_pc = cpu_pc + opnd;
              OPC_BR:   cpu_pc = cpu_pc + opnd;
              default: ;
            endcase
            if (cpu_steps != '1) cpu_steps = cpu_steps + 1;
          end
        end
      end
    endcase
    v.pc = cpu_pc; v.sp = cpu_sp; v.a = cpu_a; v.b = cpu_b;
    v.st = cpu_status; v.steps = cpu_steps;
  endtask

  // Drives one transaction after a random gap (none while idling is off), waits for acceptance, records the expectation
  task automatic send_txn(input logic [1:0] mode, input logic [11:0] addr,
                          input logic [31:0] word, input bit typed,
                          input core_view_t typed_view);
    int unsigned gap;
    core_view_t  predicted;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_mode       = mode;
    in_address    = addr;
    in_write_word = word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_core(mode, addr, word, predicted);
    pending_views.push_back(typed ? typed_view : predicted);
    items_sent++;
  endtask

  task automatic drain_results();
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  // APB write of stack_top followed by a read-back
  task automatic write_stack_top(input logic [23:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = STACK_TOP_ADDR;
    cfg_pwdata  = {8'd0, value};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_stack_top = value;
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[23:0] !== value) begin
      mismatch_count++;
      $display("%0t stack_top read-back: expected %h, got %h", $time, value,
               cfg_prdata[23:0]);
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Random instruction word: mostly legal opcodes, small operands so branches stay local
  // and shift amounts land around 32; a few halts and unknown opcodes end programs.
  function automatic logic [31:0] random_insn();
    logic [7:0]  opc;
    logic [23:0] opnd;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 88)      opc = 8'($urandom_range(0, 17));
    else if (pick < 93) opc = OPC_HALT;
    else                opc = 8'($urandom_range(19, 255));
    pick = $urandom_range(0, 99);
    if (pick < 55)      opnd = 24'(int'($urandom_range(0, 16)) - 8);
    else if (pick < 80) opnd = 24'(int'($urandom_range(0, 80)) - 40);
    else                opnd = 24'($urandom);
    return {opnd, opc};
  endfunction

  // One step of a running program. The word at PC, and the data word a load will read,
  // are planted first when undefined (and the instruction often anyway, to vary code).
  task automatic random_step();
    logic [11:0] fetch;
    logic [31:0] insn, daddr;
    if (cpu_status != RUN_ACTIVE) begin
      if ($urandom_range(0, 9) < 7) send_txn(MODE_START, 12'($urandom), $urandom, 1'b0, '0);
      else                          send_txn(MODE_STEP, 12'($urandom), $urandom, 1'b0, '0);
    end else begin
      fetch = cpu_pc[11:0];
      if (!mem_written[fetch] || $urandom_range(0, 1) == 1)
        send_txn(MODE_WR, fetch, random_insn(), 1'b0, '0);
      insn  = mem_model[fetch];
      daddr = {20'd0, fetch};
      if (insn[7:0] == OPC_LDL)
        daddr = cpu_sp + {{8{insn[31]}}, insn[31:8]};
      else if (insn[7:0] == OPC_LDNL)
        daddr = cpu_a + {{8{insn[31]}}, insn[31:8]};
      if (!mem_written[daddr[11:0]])
        send_txn(MODE_WR, daddr[11:0], $urandom, 1'b0, '0);
      send_txn(MODE_STEP, 12'($urandom), $urandom, 1'b0, '0);
    end
  endtask

  // Receiver: random stall before each result, none while idling is off
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = idle_on ? $urandom_range(0, 19) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Result checker: each accepted result against the oldest expectation, field by field
  always @(posedge clk) begin : result_check
    core_view_t  want_view;
    logic [31:0] want [0:6];
    logic [31:0] got  [0:6];
    if (rst_n && out_valid && out_ready) begin
      if (pending_views.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result: pc %h sp %h a %h", $time, out_pc_value,
                 out_sp_value, out_reg_a);
      end else begin
        want_view = pending_views.pop_front();
        want = '{want_view.rd, want_view.pc, want_view.sp, want_view.a, want_view.b,
                 {30'd0, want_view.st}, want_view.steps};
        got  = '{out_read_word, out_pc_value, out_sp_value, out_reg_a, out_reg_b,
                 {30'd0, out_run_status}, out_steps_done};
        for (int i = 0; i < 7; i++) begin
          if (got[i] !== want[i]) begin
            mismatch_count++;
            $display("%0t %s: expected %h, got %h", $time, field_names[i], want[i], got[i]);
          end
        end
      end
    end
  end

  // Directed table. Program at words 0..4: ldc 5 / ldl 1 / ldc -1 / shr / halt.
  // After reset SP is 8388607, so ldl 1 reads word 0 through the address wrap; shr by
  // a negative A is a huge shift. Later rows hit an unknown opcode, stepping while
  // stopped, the extreme operands and a branch far below zero.
  initial begin
    core_view_t reset_view;
    reset_view = make_view('0, '0, {8'd0, STACK_TOP_RESET}, '0, '0, RUN_ACTIVE, '0);
    directed_rows.push_back('{MODE_WR,    12'd0,    32'h0000_0500, 1'b1, reset_view});
    directed_rows.push_back('{MODE_WR,    12'd4095, 32'hFFFF_FFFF, 1'b1, reset_view});
    directed_rows.push_back('{MODE_RD,    12'd4095, 32'h0000_0000, 1'b1,
                              make_view(32'hFFFF_FFFF, '0, {8'd0, STACK_TOP_RESET}, '0, '0,
                                        RUN_ACTIVE, '0)});
    directed_rows.push_back('{MODE_WR,    12'd1,    {24'd1, OPC_LDL},      1'b0, '0});
    directed_rows.push_back('{MODE_WR,    12'd2,    {24'hFFFFFF, OPC_LDC}, 1'b0, '0});
    directed_rows.push_back('{MODE_WR,    12'd3,    {24'd0, OPC_SHR},      1'b0, '0});
    directed_rows.push_back('{MODE_WR,    12'd4,    {24'd0, OPC_HALT},     1'b0, '0});
    // step before any start runs from the reset registers
    directed_rows.push_back('{MODE_STEP,  12'd0,    32'h0,         1'b1,
                              make_view('0, 32'd1, {8'd0, STACK_TOP_RESET}, 32'd5, '0,
                                        RUN_ACTIVE, 32'd1)});
    directed_rows.push_back('{MODE_STEP,  12'hFFF,  32'hFFFF_FFFF, 1'b0, '0});
    directed_rows.push_back('{MODE_STEP,  12'd0,    32'h0,         1'b0, '0});
    directed_rows.push_back('{MODE_STEP,  12'd0,    32'h0,         1'b0, '0});
    directed_rows.push_back('{MODE_STEP,  12'd0,    32'h0,         1'b0, '0});
    directed_rows.push_back('{MODE_STEP,  12'd0,    32'h0,         1'b0, '0});
    directed_rows.push_back('{MODE_START, 12'hFFF,  32'hFFFF_FFFF, 1'b1, reset_view});
    directed_rows.push_back('{MODE_RD,    12'd0,    32'h0,         1'b1,
                              make_view(32'h0000_0500, '0, {8'd0, STACK_TOP_RESET}, '0, '0,
                                        RUN_ACTIVE, '0)});
    directed_rows.push_back('{MODE_WR,    12'd0,    {24'd0, 8'hFF},        1'b0, '0});
    // unknown opcode stops without moving PC or counting
    directed_rows.push_back('{MODE_STEP,  12'd0,    32'h0,         1'b1,
                              make_view('0, '0, {8'd0, STACK_TOP_RESET}, '0, '0,
                                        RUN_BADOP, '0)});
    directed_rows.push_back('{MODE_STEP,  12'd0,    32'h0,         1'b0, '0});
    directed_rows.push_back('{MODE_WR,    12'd0,    {24'h7FFFFF, OPC_LDC}, 1'b0, '0});
    directed_rows.push_back('{MODE_WR,    12'd4,    {24'h800000, OPC_BR},  1'b0, '0});
    directed_rows.push_back('{MODE_START, 12'd0,    32'h0,         1'b1, reset_view});
    for (int i = 0; i < 5; i++)
      directed_rows.push_back('{MODE_STEP, 12'd0, 32'h0, 1'b0, '0});
  end

  // Main sequence: reset, directed table, random phases with changing stack_top
  initial begin
    int unsigned phase_end, pick, idx;
    logic [23:0] top_value;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = MODE_WR;
    in_address    = '0;
    in_write_word = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    cpu_pc        = '0;
    cpu_sp        = {8'd0, STACK_TOP_RESET};
    cpu_a         = '0;
    cpu_b         = '0;
    cpu_status    = RUN_ACTIVE;
    cpu_steps     = '0;
    cfg_stack_top = STACK_TOP_RESET;
    idle_on       = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_txn(directed_rows[i].mode, directed_rows[i].addr, directed_rows[i].word,
               directed_rows[i].typed, directed_rows[i].view);

    for (int phase = 0; phase < PHASES; phase++) begin
      // sender holds off until the core is idle before touching the register
      @(negedge clk);
      in_valid = 1'b0;
      drain_results();
      case (phase)
        0:       top_value = 24'd0;
        1:       top_value = 24'hFFFFFF;
        default: top_value = 24'($urandom);
      endcase
      write_stack_top(top_value);
      idle_on   = (phase % 3) != 2;    // every third phase runs at full rate
      phase_end = items_sent + RANDOM_ITEMS / PHASES;
      send_txn(MODE_START, 12'($urandom), $urandom, 1'b0, '0);
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          send_txn(MODE_WR, 12'($urandom), $urandom, 1'b0, '0);
        end else if (pick < 15 && written_addrs.size() != 0) begin
          idx = $urandom_range(0, written_addrs.size() - 1);
          send_txn(MODE_RD, 12'(written_addrs[idx]), $urandom, 1'b0, '0);
        end else if (pick < 18) begin
          send_txn(MODE_START, 12'($urandom), $urandom, 1'b0, '0);
        end else begin
          random_step();
        end
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_views.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
